// ----- rtl/core/rxc_pkg.sv -----
// rxc_pkg: shared types, constants and the byte-wide crc32 update for the
// rolling xor cipher with crc tag; no dependencies
package rxc_pkg;

  // reflected crc32 polynomial and preset
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // cipher mode codes (any other code runs as rolling)
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_REPEAT = 2'd1;

  // register indexes of the configuration port
  localparam logic [2:0] REG_CIPHER_MODE = 3'd0;
  localparam logic [2:0] REG_DECRYPT     = 3'd1;
  localparam logic [2:0] REG_INTEGRITY   = 3'd2;
  localparam logic [2:0] REG_KEY_0       = 3'd3;
  localparam logic [2:0] REG_KEY_1       = 3'd4;
  localparam logic [2:0] REG_KEY_2       = 3'd5;
  localparam logic [2:0] REG_KEY_3       = 3'd6;

  // what follows the optional data word of a job
  localparam logic [1:0] TAIL_NONE   = 2'd0;
  localparam logic [1:0] TAIL_TAG    = 2'd1;
  localparam logic [1:0] TAIL_STATUS = 2'd2;

  // live configuration seen by the front end
  typedef struct packed {
    logic [1:0]   mode;
    logic         dec;
    logic         integ;
    logic [255:0] key;
  } cfg_t;

  // one queued job: an optional data word, then an optional tail
  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data;
    logic        data_end;
    logic [1:0]  tail;
    logic [31:0] tag;
    logic        err;
  } job_t;

  // one byte through the reflected crc32, bit by bit
  function automatic logic [31:0] crc8_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/rxc_queue.sv -----
// rxc_queue: small first-in first-out queue of jobs between front and back
// depends on rxc_pkg for the job type
module rxc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rxc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rxc_pkg::job_t head_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rxc_pkg::job_t     slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/rxc_front.sv -----
// rxc_front: accepts message bytes, runs the key stream, crc and tag hold-back
// and turns each word into a job; depends on rxc_pkg
module rxc_front (
  input  logic          clk,
  input  logic          rst,
  input  rxc_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          q_full,
  output logic          push,
  output rxc_pkg::job_t job
);

  logic        msg_active;
  logic [1:0]  lat_mode;
  logic        lat_dec;
  logic        lat_integ;
  logic [31:0] rolling_key;
  logic [4:0]  key_position;
  logic [31:0] running_crc;
  logic [7:0]  held [4];
  logic [2:0]  held_count;

  logic [1:0]  mode;
  logic        dec;
  logic        integ;
  logic [31:0] rk0;
  logic [4:0]  kp0;
  logic [31:0] crc0;
  logic [2:0]  hc0;
  logic        hold_path;
  logic        release_old;
  logic        do_xf;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [31:0] rolling_key_next;
  logic [4:0]  key_position_next;
  logic [31:0] running_crc_next;
  logic [7:0]  held_next [4];
  logic [2:0]  held_count_next;
  logic [31:0] tag;
  logic [31:0] stored;
  logic        have4;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // message context: latched at the first word, live key
  always_comb begin
    if (!msg_active) begin
      mode  = cfg.mode;
      dec   = cfg.dec;
      integ = cfg.integ;
      rk0   = cfg.key[31:0];
      kp0   = '0;
      crc0  = rxc_pkg::CRC_INIT;
      hc0   = '0;
    end else begin
      mode  = lat_mode;
      dec   = lat_dec;
      integ = lat_integ;
      rk0   = rolling_key;
      kp0   = key_position;
      crc0  = running_crc;
      hc0   = held_count;
    end
  end

  // key stream, crc and hold-back window
  always_comb begin
    hold_path   = dec && integ;
    release_old = hold_path && hc0[2];
    do_xf       = !hold_path || release_old;
    x           = release_old ? held[0] : data_byte;

    y                 = x;
    rolling_key_next  = rk0;
    key_position_next = kp0;
    if (do_xf) begin
      if (mode == rxc_pkg::MODE_NONE) begin
        y = x;
      end else if (mode == rxc_pkg::MODE_REPEAT) begin
        y                 = x ^ cfg.key[{kp0, 3'b000} +: 8];
        key_position_next = kp0 + 5'd1;
      end else begin
        y                = x ^ rk0[7:0];
        rolling_key_next = {rk0[7:0], rk0[31:8]} ^ {24'h0, (dec ? x : y)};
      end
    end

    // crc runs over ciphertext only
    if (!dec || release_old) begin
      running_crc_next = rxc_pkg::crc8_update(crc0, dec ? x : y);
    end else begin
      running_crc_next = crc0;
    end
    tag = ~running_crc_next ^ {cfg.key[199:192], cfg.key[135:128],
                               cfg.key[71:64], cfg.key[7:0]};

    held_next       = held;
    held_count_next = hc0;
    if (hold_path) begin
      if (release_old) begin
        held_next[0] = held[1];
        held_next[1] = held[2];
        held_next[2] = held[3];
        held_next[3] = data_byte;
      end else begin
        held_next[hc0[1:0]] = data_byte;
        held_count_next     = hc0 + 3'd1;
      end
    end
    have4  = release_old || (hc0 == 3'd3);
    stored = {held_next[3], held_next[2], held_next[1], held_next[0]};
  end

  // job built from this word
  always_comb begin
    job.data     = y;
    job.tag      = tag;
    job.err      = !(have4 && (stored == tag));
    if (!dec) begin
      job.data_valid = 1'b1;
      job.data_end   = last_byte && !integ;
      job.tail       = (last_byte && integ) ? rxc_pkg::TAIL_TAG : rxc_pkg::TAIL_NONE;
    end else if (!integ) begin
      job.data_valid = 1'b1;
      job.data_end   = last_byte;
      job.tail       = rxc_pkg::TAIL_NONE;
    end else begin
      job.data_valid = release_old;
      job.data_end   = 1'b0;
      job.tail       = last_byte ? rxc_pkg::TAIL_STATUS : rxc_pkg::TAIL_NONE;
    end
    push = accept && (job.data_valid || (job.tail != rxc_pkg::TAIL_NONE));
  end

  // held window, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_active   <= 1'b0;
      lat_mode     <= rxc_pkg::MODE_NONE;
      lat_dec      <= 1'b0;
      lat_integ    <= 1'b0;
      rolling_key  <= '0;
      key_position <= '0;
      running_crc  <= rxc_pkg::CRC_INIT;
      held_count   <= '0;
    end else if (accept) begin
      msg_active   <= !last_byte;
      lat_mode     <= mode;
      lat_dec      <= dec;
      lat_integ    <= integ;
      rolling_key  <= rolling_key_next;
      key_position <= key_position_next;
      running_crc  <= running_crc_next;
      held_count   <= held_count_next;
    end
  end

endmodule

// ----- rtl/core/rxc_back.sv -----
// rxc_back: expands queued jobs into output words through an output register
// depends on rxc_pkg for the job type and tail codes
module rxc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  rxc_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          end_of_message,
  output logic          tag_error
);

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [1:0] tidx;
  logic       load;
  logic       job_last;
  logic [7:0] res_byte;
  logic       res_bv;
  logic       res_end;
  logic       res_err;

  assign load = head_valid && (!out_valid || out_ready);

  // pick the word for the current phase of the head job
  always_comb begin
    tidx = head_job.data_valid ? 2'(phase - 3'd1) : phase[1:0];
    priority if ((phase == 3'd0) && head_job.data_valid) begin
      res_byte = head_job.data;
      res_bv   = 1'b1;
      res_end  = head_job.data_end;
      res_err  = 1'b0;
      job_last = (head_job.tail == rxc_pkg::TAIL_NONE);
    end else if (head_job.tail == rxc_pkg::TAIL_TAG) begin
      res_byte = head_job.tag[{tidx, 3'b000} +: 8];
      res_bv   = 1'b1;
      res_end  = (tidx == 2'd3);
      res_err  = 1'b0;
      job_last = (tidx == 2'd3);
    end else begin
      res_byte = 8'h00;
      res_bv   = 1'b0;
      res_end  = 1'b1;
      res_err  = head_job.err;
      job_last = 1'b1;
    end
    pop        = load && job_last;
    phase_next = job_last ? 3'd0 : phase + 3'd1;
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= res_byte;
      byte_valid     <= res_bv;
      end_of_message <= res_end;
      tag_error      <= res_err;
    end
  end

  // output valid and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= phase_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/rolling_xor_cipher_crc_tag.sv -----
// rolling_xor_cipher_crc_tag: top level, configuration registers and wiring
// depends on rxc_pkg, rxc_front, rxc_queue and rxc_back
//
// Streaming byte cipher with an optional keyed crc32 tag. One message byte is
// taken per cycle on the input channel unless the job queue is full; a byte
// with last_byte set closes the message, and the mode, direction and integrity
// settings are latched at the first byte of each message while the key is
// read live. The front end updates the key stream, crc and the four-byte tag
// hold-back as each byte is accepted and queues a job of up to five output
// words; the back end drains one word per cycle through an output register
// while out_ready is high. A plain byte passes through the job queue and then
// the output register, so bytes stream at one per cycle without stalls. The
// closing byte of a tagged encrypt yields five output words, of a tagged
// decrypt up to two, absorbed by the QUEUE_DEPTH-entry job queue until it
// fills. Configuration is written through cfg_we, cfg_index and cfg_wdata;
// the user must do so only while the block is idle; it is not enforced.
module rolling_xor_cipher_crc_tag #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        end_of_message,
  output logic        tag_error
);

  logic [1:0]    cipher_mode;
  logic          decrypt_select;
  logic          integrity_enable;
  logic [63:0]   key_word [4];
  rxc_pkg::cfg_t cfg;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  rxc_pkg::job_t push_job;
  rxc_pkg::job_t head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode      <= rxc_pkg::MODE_NONE;
      decrypt_select   <= 1'b0;
      integrity_enable <= 1'b0;
      key_word[0]      <= '0;
      key_word[1]      <= '0;
      key_word[2]      <= '0;
      key_word[3]      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rxc_pkg::REG_CIPHER_MODE: cipher_mode      <= cfg_wdata[1:0];
        rxc_pkg::REG_DECRYPT:     decrypt_select   <= cfg_wdata[0];
        rxc_pkg::REG_INTEGRITY:   integrity_enable <= cfg_wdata[0];
        rxc_pkg::REG_KEY_0:       key_word[0]      <= cfg_wdata;
        rxc_pkg::REG_KEY_1:       key_word[1]      <= cfg_wdata;
        rxc_pkg::REG_KEY_2:       key_word[2]      <= cfg_wdata;
        rxc_pkg::REG_KEY_3:       key_word[3]      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.mode  = cipher_mode;
  assign cfg.dec   = decrypt_select;
  assign cfg.integ = integrity_enable;
  assign cfg.key   = {key_word[3], key_word[2], key_word[1], key_word[0]};

  // front end: accept and classify
  rxc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (q_push),
    .job       (push_job)
  );

  // job queue
  rxc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // back end: expand jobs into output words
  rxc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_valid),
    .head_job       (head_job),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .tag_error      (tag_error)
  );

  // a status word carries no byte and always closes the message
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> end_of_message && (out_byte == 8'h00))
    else $error("status word with data or without end");

  // tag errors only appear on the status word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && tag_error |-> !byte_valid && end_of_message)
    else $error("tag error on a data word");

  // the back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty job queue");

  // a full queue blocks the front end
  assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("push into full job queue");

endmodule
